[sv/pan_tilt_servo_tracker_top_assert.svh]
// Assertion macros for the pan/tilt servo tracker.
`ifndef PAN_TILT_SERVO_TRACKER_TOP_ASSERT_SVH
`define PAN_TILT_SERVO_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pts_pkg.sv]
// Shared types and constants of the pan/tilt servo tracker.
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

    typedef logic [7:0] t_byte;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_SERVO_ID  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_SERVO_ID = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_DURATION = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_LOW      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_HIGH     = 3'd7;

    // Packet framing bytes.
    localparam t_byte PKT_SYNC  = 8'h55;
    localparam t_byte PKT_LEN   = 8'h08;
    localparam t_byte PKT_CMD   = 8'h03;
    localparam t_byte PKT_COUNT = 8'h01;

    // Byte positions within one 10-byte packet.
    localparam logic [3:0] POS_SYNC0   = 4'd0;
    localparam logic [3:0] POS_SYNC1   = 4'd1;
    localparam logic [3:0] POS_LEN     = 4'd2;
    localparam logic [3:0] POS_CMD     = 4'd3;
    localparam logic [3:0] POS_COUNT   = 4'd4;
    localparam logic [3:0] POS_DUR_LO  = 4'd5;
    localparam logic [3:0] POS_DUR_HI  = 4'd6;
    localparam logic [3:0] POS_ID      = 4'd7;
    localparam logic [3:0] POS_POS_LO  = 4'd8;
    localparam logic [3:0] POS_POS_HI  = 4'd9;

    localparam int PKT_BYTES   = 10;
    localparam int TOTAL_BYTES = 20;

    // Pan travel hold and reset positions.
    localparam int PAN_HOLD_LOW  = 800;
    localparam int PAN_HOLD_HIGH = 2600;
    localparam int PAN_REHOME    = 2400;
    localparam int PAN_RESET     = 1500;
    localparam int TILT_RESET_Q3 = 12000;

endpackage

`default_nettype wire

[sv/pts_centroid_if.sv]
// Centroid input channel: valid/ready with the target position.
`timescale 1ns / 1ps
`default_nettype none

interface pts_centroid_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] centroid_x;
    logic [COORD_BITS-1:0] centroid_y;

    modport source (output valid, output centroid_x, output centroid_y, input ready);
    modport sink   (input valid, input centroid_x, input centroid_y, output ready);
endinterface

`default_nettype wire

[sv/pts_byte_if.sv]
// Packet byte output channel: valid/ready with one byte and a last marker.
`timescale 1ns / 1ps
`default_nettype none

interface pts_byte_if;
    logic          valid;
    logic          ready;
    pts_pkg::t_byte tx_byte;
    logic          last_byte;

    modport source (output valid, output tx_byte, output last_byte, input ready);
    modport sink   (input valid, input tx_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[sv/pan_tilt_servo_tracker_top.sv]
// Pan/tilt servo tracker: centroid in, two servo move packets out.
//
//   channel     dir  handshake      payload
//   i_centroid  in   valid/ready    centroid_x, centroid_y
//   o_byte      out  valid/ready    tx_byte, last_byte
//   i_cfg_*     in   write enable   register index, write data
//
// Each centroid yields 20 output bytes, one per cycle when the output is not
// stalled, so the byte serializer sets the sustained rate.
// The servo update is combinational logic between the input register and the
// serializer. A new centroid is taken while the previous packets still go out.
// Reset is synchronous, active low; it restores commands and config registers.
// Output stalls hold the byte counter; input stalls only when both stages hold.
`timescale 1ns / 1ps
`default_nettype none

module pan_tilt_servo_tracker_top #(
    parameter int COORD_BITS = 12
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    pts_centroid_if.sink                     i_centroid,
    pts_byte_if.source                       o_byte,
    input  wire                              i_cfg_we,
    input  wire [pts_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [pts_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

`include "pan_tilt_servo_tracker_top_assert.svh"

    localparam int PAN_W  = COORD_BITS + 6;
    localparam int QW     = COORD_BITS + 8;
    localparam int TILT_W = COORD_BITS + 10;
    localparam logic [4:0] LAST_IDX = 5'(pts_pkg::TOTAL_BYTES - 1);
    localparam logic [4:0] TILT_IDX = 5'(pts_pkg::PKT_BYTES);

    // Configuration registers.
    logic [COORD_BITS-1:0] r_width, r_height;
    logic [9:0]            r_max_step;
    logic [7:0]            r_pan_id, r_tilt_id;
    logic [15:0]           r_duration;
    logic [11:0]           r_tilt_low, r_tilt_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= COORD_BITS'(640);
            r_height    <= COORD_BITS'(480);
            r_max_step  <= 10'd100;
            r_pan_id    <= 8'd6;
            r_tilt_id   <= 8'd3;
            r_duration  <= 16'd40;
            r_tilt_low  <= 12'd1300;
            r_tilt_high <= 12'd2600;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pts_pkg::REG_IMAGE_WIDTH:   r_width     <= i_cfg_data[COORD_BITS-1:0];
                pts_pkg::REG_IMAGE_HEIGHT:  r_height    <= i_cfg_data[COORD_BITS-1:0];
                pts_pkg::REG_MAX_STEP:      r_max_step  <= i_cfg_data[9:0];
                pts_pkg::REG_PAN_SERVO_ID:  r_pan_id    <= i_cfg_data[7:0];
                pts_pkg::REG_TILT_SERVO_ID: r_tilt_id   <= i_cfg_data[7:0];
                pts_pkg::REG_MOVE_DURATION: r_duration  <= i_cfg_data[15:0];
                pts_pkg::REG_TILT_LOW:      r_tilt_low  <= i_cfg_data[11:0];
                pts_pkg::REG_TILT_HIGH:     r_tilt_high <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Input register.
    logic                  r_in_v;
    logic [COORD_BITS-1:0] r_cx, r_cy;

    // Servo state. Pan and its previous value are always equal after a step.
    logic signed [PAN_W-1:0]  r_pan;
    logic signed [TILT_W-1:0] r_tilt_prev;
    logic [14:0]              r_tilt_cmd;

    // Byte serializer.
    logic        r_ser_v;
    logic [4:0]  r_cnt;
    logic [15:0] r_pan_pos;
    logic [11:0] r_tilt_pos;

    logic w_last_taken, w_load, w_in_take;
    assign w_last_taken = r_ser_v && (r_cnt == LAST_IDX) && o_byte.ready;
    assign w_load       = r_in_v && (!r_ser_v || w_last_taken);
    assign w_in_take    = i_centroid.valid && i_centroid.ready;
    assign i_centroid.ready = !r_in_v || w_load;

    // Pan update.
    logic signed [PAN_W-1:0] pan_held, n_pan;
    logic signed [QW-1:0]    quarters, pan_want, pan_prev, pan_lim, pan_d, pan_slew;
    logic signed [31:0]      pan_ext;

    always_comb begin
        if (r_pan < PAN_W'(pts_pkg::PAN_HOLD_LOW)) begin
            pan_held = PAN_W'(pts_pkg::PAN_HOLD_LOW);
        end else if (r_pan > PAN_W'(pts_pkg::PAN_HOLD_HIGH)) begin
            pan_held = PAN_W'(pts_pkg::PAN_REHOME);
        end else begin
            pan_held = r_pan;
        end
        quarters = (QW'(pan_held) <<< 2) + QW'(signed'({1'b0, r_width}))
                   - QW'(signed'({1'b0, r_cx, 1'b0}));
        // Divide by four, truncating toward zero.
        pan_want = (quarters >>> 2)
                   + QW'(signed'({1'b0, quarters[QW-1] && (quarters[1:0] != 2'b00)}));
        pan_prev = QW'(r_pan);
        pan_lim  = QW'(signed'({1'b0, r_max_step}));
        pan_d    = pan_want - pan_prev;
        if (pan_d > pan_lim) begin
            pan_slew = pan_prev + pan_lim;
        end else if (pan_d < -pan_lim) begin
            pan_slew = pan_prev - pan_lim;
        end else begin
            pan_slew = pan_want;
        end
        n_pan   = PAN_W'(pan_slew);
        pan_ext = 32'(n_pan);
    end

    // Tilt update, in eighths.
    logic signed [TILT_W-1:0] h_ext, tilt_want, tilt_d, tilt_lim, n_tilt_prev;
    logic signed [TILT_W-1:0] hi_q3, lo_q3, tilt_clamped;
    logic [14:0]              n_tilt_cmd;

    always_comb begin
        h_ext     = TILT_W'(signed'({1'b0, r_height}));
        tilt_want = TILT_W'(signed'({1'b0, r_tilt_cmd})) + (h_ext <<< 1) + h_ext
                    - TILT_W'(signed'({1'b0, r_cy, 2'b00}));
        tilt_lim  = TILT_W'(signed'({1'b0, r_max_step, 3'b000}));
        tilt_d    = tilt_want - r_tilt_prev;
        if (tilt_d > tilt_lim) begin
            n_tilt_prev = r_tilt_prev + tilt_lim;
        end else if (tilt_d < -tilt_lim) begin
            n_tilt_prev = r_tilt_prev - tilt_lim;
        end else begin
            n_tilt_prev = tilt_want;
        end
        hi_q3 = TILT_W'(signed'({1'b0, r_tilt_high, 3'b000}));
        lo_q3 = TILT_W'(signed'({1'b0, r_tilt_low, 3'b000}));
        tilt_clamped = n_tilt_prev;
        // Upper clamp first, so crossed limits settle on the lower one.
        if (tilt_clamped > hi_q3) begin
            tilt_clamped = hi_q3;
        end
        if (tilt_clamped < lo_q3) begin
            tilt_clamped = lo_q3;
        end
        n_tilt_cmd = tilt_clamped[14:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v      <= 1'b0;
            r_ser_v     <= 1'b0;
            r_cnt       <= 5'd0;
            r_pan       <= PAN_W'(pts_pkg::PAN_RESET);
            r_tilt_prev <= TILT_W'(pts_pkg::TILT_RESET_Q3);
            r_tilt_cmd  <= 15'(pts_pkg::TILT_RESET_Q3);
        end else begin
            if (w_in_take) begin
                r_in_v <= 1'b1;
            end else if (w_load) begin
                r_in_v <= 1'b0;
            end
            if (w_load) begin
                r_ser_v     <= 1'b1;
                r_cnt       <= 5'd0;
                r_pan       <= n_pan;
                r_tilt_prev <= n_tilt_prev;
                r_tilt_cmd  <= n_tilt_cmd;
            end else if (w_last_taken) begin
                r_ser_v <= 1'b0;
                r_cnt   <= 5'd0;
            end else if (r_ser_v && o_byte.ready) begin
                r_cnt <= r_cnt + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_cx <= i_centroid.centroid_x;
            r_cy <= i_centroid.centroid_y;
        end
        if (w_load) begin
            r_pan_pos  <= pan_ext[15:0];
            r_tilt_pos <= n_tilt_cmd[14:3];
        end
    end

    // Byte selection.
    logic        is_tilt;
    logic [3:0]  pkt_pos;
    logic [7:0]  sel_id;
    logic [15:0] sel_pos;
    pts_pkg::t_byte byte_mux;

    always_comb begin
        is_tilt = (r_cnt >= TILT_IDX);
        pkt_pos = is_tilt ? 4'(r_cnt - TILT_IDX) : r_cnt[3:0];
        sel_id  = is_tilt ? r_tilt_id : r_pan_id;
        sel_pos = is_tilt ? {4'b0000, r_tilt_pos} : r_pan_pos;
        case (pkt_pos)
            pts_pkg::POS_SYNC0:  byte_mux = pts_pkg::PKT_SYNC;
            pts_pkg::POS_SYNC1:  byte_mux = pts_pkg::PKT_SYNC;
            pts_pkg::POS_LEN:    byte_mux = pts_pkg::PKT_LEN;
            pts_pkg::POS_CMD:    byte_mux = pts_pkg::PKT_CMD;
            pts_pkg::POS_COUNT:  byte_mux = pts_pkg::PKT_COUNT;
            pts_pkg::POS_DUR_LO: byte_mux = r_duration[7:0];
            pts_pkg::POS_DUR_HI: byte_mux = r_duration[15:8];
            pts_pkg::POS_ID:     byte_mux = sel_id;
            pts_pkg::POS_POS_LO: byte_mux = sel_pos[7:0];
            pts_pkg::POS_POS_HI: byte_mux = sel_pos[15:8];
            default:             byte_mux = 8'h00;
        endcase
    end

    assign o_byte.valid     = r_ser_v;
    assign o_byte.tx_byte   = byte_mux;
    assign o_byte.last_byte = (r_cnt == LAST_IDX);

    `PTS_ASSERT_NOW(a_cnt_range, r_ser_v, r_cnt <= LAST_IDX, "byte counter past packet end")
    `PTS_ASSERT_NEXT(a_in_held, r_in_v && !w_load, r_in_v && $stable(r_cx) && $stable(r_cy), "pending centroid lost")
    `PTS_ASSERT_NEXT(a_back_to_back, w_last_taken && r_in_v, r_ser_v && (r_cnt == 5'd0), "queued centroid not started after last byte")
    `PTS_ASSERT_NOW(a_idle_cnt, !r_ser_v, r_cnt == 5'd0, "byte counter not cleared while idle")

endmodule

`default_nettype wire
